@@ sv/tracking_error_time_scale_unit_defines.svh @@
// assertion macros for the tracking error time scale unit
`ifndef TRACKING_ERROR_TIME_SCALE_UNIT_DEFINES_SVH
`define TRACKING_ERROR_TIME_SCALE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TETS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tets check failed");
// next-cycle implication
`define TETS_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tets check failed");
`else
`define TETS_ASSERT_IMP(name, ante, cons)
`define TETS_ASSERT_NXT(name, ante, cons)
`endif

`endif

@@ sv/tets_pkg.sv @@
package tets_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int DATA_W    = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INV_POS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_VEL      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_WEIGHT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHRINK_GAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SCALE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA = 3'd5;

	// register reset values
	localparam logic [DATA_W-1:0] RST_INV_POS      = 16'd5120;
	localparam logic [DATA_W-1:0] RST_INV_VEL      = 16'd512;
	localparam logic [DATA_W-1:0] RST_VEL_WEIGHT   = 16'd19661;
	localparam logic [DATA_W-1:0] RST_SHRINK_GAIN  = 16'd6144;
	localparam logic [DATA_W-1:0] RST_MIN_SCALE    = 16'd4915;
	localparam logic [DATA_W-1:0] RST_FILTER_ALPHA = 16'd19661;

	localparam logic [DATA_W-1:0] Q15_ONE = 16'h8000;
	localparam logic [DATA_W-1:0] SAT16   = 16'hFFFF;

	// multiplier operand select
	localparam int MS_W = 3;
	localparam logic [MS_W-1:0] MS_POS   = 3'd0;
	localparam logic [MS_W-1:0] MS_VEL   = 3'd1;
	localparam logic [MS_W-1:0] MS_LAM   = 3'd2;
	localparam logic [MS_W-1:0] MS_KZ    = 3'd3;
	localparam logic [MS_W-1:0] MS_ALPHA = 3'd4;

	// divider
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = 4;
	localparam int NUM_W     = 36;
	localparam int DEN_W     = 33;
	localparam int DSH_W     = DEN_W + DIV_STEPS - 1;

	typedef struct packed {
		logic [DATA_W-1:0] inv_pos;
		logic [DATA_W-1:0] inv_vel;
		logic [DATA_W-1:0] vel_weight;
		logic [DATA_W-1:0] shrink_gain;
		logic [DATA_W-1:0] min_scale;
		logic [DATA_W-1:0] filter_alpha;
	} cfg_t;

	typedef struct packed {
		logic            load;
		logic            mul_en;
		logic [MS_W-1:0] mul_sel;
		logic            upd_pos;
		logic            upd_vel;
		logic            z_en;
		logic            div_init;
		logic            div_step;
		logic            raw_en;
		logic            fin_en;
	} cmd_t;

	typedef struct packed {
		logic last;
	} stat_t;

endpackage

@@ sv/tets_regs.sv @@
module tets_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tets_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tets_pkg::DATA_W-1:0]       cfg_data,
	output tets_pkg::cfg_t                    cfg
);

	tets_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_pos      <= tets_pkg::RST_INV_POS;
			cfg_q.inv_vel      <= tets_pkg::RST_INV_VEL;
			cfg_q.vel_weight   <= tets_pkg::RST_VEL_WEIGHT;
			cfg_q.shrink_gain  <= tets_pkg::RST_SHRINK_GAIN;
			cfg_q.min_scale    <= tets_pkg::RST_MIN_SCALE;
			cfg_q.filter_alpha <= tets_pkg::RST_FILTER_ALPHA;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tets_pkg::REG_INV_POS:      cfg_q.inv_pos      <= cfg_data;
				tets_pkg::REG_INV_VEL:      cfg_q.inv_vel      <= cfg_data;
				tets_pkg::REG_VEL_WEIGHT:   cfg_q.vel_weight   <= cfg_data;
				tets_pkg::REG_SHRINK_GAIN:  cfg_q.shrink_gain  <= cfg_data;
				tets_pkg::REG_MIN_SCALE:    cfg_q.min_scale    <= cfg_data;
				tets_pkg::REG_FILTER_ALPHA: cfg_q.filter_alpha <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/tets_ctrl.sv @@
module tets_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  tets_pkg::stat_t   stat,
	output tets_pkg::cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PE   = 4'd1;
	localparam logic [3:0] ST_VE   = 4'd2;
	localparam logic [3:0] ST_UV   = 4'd3;
	localparam logic [3:0] ST_LAM  = 4'd4;
	localparam logic [3:0] ST_ZS   = 4'd5;
	localparam logic [3:0] ST_KZ   = 4'd6;
	localparam logic [3:0] ST_DI   = 4'd7;
	localparam logic [3:0] ST_DIV  = 4'd8;
	localparam logic [3:0] ST_RAW  = 4'd9;
	localparam logic [3:0] ST_FM   = 4'd10;
	localparam logic [3:0] ST_FIN  = 4'd11;

	logic [3:0]                     state_q, state_d;
	logic [tets_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           out_valid_q;
	logic                           out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PE;
				end
			end
			ST_PE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tets_pkg::MS_POS;
				state_d     = ST_VE;
			end
			ST_VE: begin
				cmd.upd_pos = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tets_pkg::MS_VEL;
				state_d     = ST_UV;
			end
			ST_UV: begin
				cmd.upd_vel = 1'b1;
				state_d     = stat.last ? ST_LAM : ST_IDLE;
			end
			ST_LAM: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tets_pkg::MS_LAM;
				state_d     = ST_ZS;
			end
			ST_ZS: begin
				cmd.z_en = 1'b1;
				state_d  = ST_KZ;
			end
			ST_KZ: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tets_pkg::MS_KZ;
				state_d     = ST_DI;
			end
			ST_DI: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == tets_pkg::DIV_CNT_W'(tets_pkg::DIV_STEPS - 1)) begin
					state_d = ST_RAW;
				end
			end
			ST_RAW: begin
				cmd.raw_en = 1'b1;
				state_d    = ST_FM;
			end
			ST_FM: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tets_pkg::MS_ALPHA;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.fin_en = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.fin_en) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ sv/tets_dp.sv @@
module tets_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tets_pkg::cfg_t                cfg,
	input  tets_pkg::cmd_t                cmd,
	output tets_pkg::stat_t               stat,
	input  logic signed [15:0]            pos_ref,
	input  logic signed [15:0]            pos_meas,
	input  logic signed [15:0]            vel_ref,
	input  logic signed [15:0]            vel_meas,
	input  logic                          last_joint,
	output logic [tets_pkg::DATA_W-1:0]   speed_scale
);

	// input words
	logic [15:0] abs_pos_q, abs_vel_q;
	logic        last_q;
	logic signed [16:0] dpos, dvel;
	logic [16:0] apos, avel;

	// shared multiplier
	logic [15:0] mul_a, mul_b;
	logic [31:0] mul_q;

	// running state
	logic [15:0] max_pos_q, max_vel_q, scale_q, z_q;
	logic [15:0] pos_err, vel_err;
	logic [16:0] z_sum;

	// divider
	logic [tets_pkg::NUM_W-1:0] rem_q;
	logic [tets_pkg::DSH_W-1:0] dsh_q;
	logic [15:0]                quot_q;
	logic [15:0]                span;
	logic [tets_pkg::DEN_W-1:0] denom;
	logic                       ge;

	// filter
	logic [15:0] smin, raw, diff_q;
	logic [16:0] raw_sum, s_sum;
	logic [15:0] s_new;
	logic        up_q;

	assign dpos = 17'(pos_ref) - 17'(pos_meas);
	assign dvel = 17'(vel_ref) - 17'(vel_meas);
	assign apos = dpos[16] ? 17'(-dpos) : 17'(dpos);
	assign avel = dvel[16] ? 17'(-dvel) : 17'(dvel);

	always_comb begin
		case (cmd.mul_sel)
			tets_pkg::MS_POS: begin
				mul_a = abs_pos_q;
				mul_b = cfg.inv_pos;
			end
			tets_pkg::MS_VEL: begin
				mul_a = abs_vel_q;
				mul_b = cfg.inv_vel;
			end
			tets_pkg::MS_LAM: begin
				mul_a = cfg.vel_weight;
				mul_b = max_vel_q;
			end
			tets_pkg::MS_KZ: begin
				mul_a = cfg.shrink_gain;
				mul_b = z_q;
			end
			tets_pkg::MS_ALPHA: begin
				mul_a = cfg.filter_alpha;
				mul_b = diff_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Q8.8 errors, saturated
	assign pos_err = (|mul_q[31:28]) ? tets_pkg::SAT16 : mul_q[27:12];
	assign vel_err = (|mul_q[31:26]) ? tets_pkg::SAT16 : mul_q[25:10];
	assign z_sum   = {1'b0, max_pos_q} + {1'b0, mul_q[31:16]};

	assign smin  = (cfg.min_scale > tets_pkg::Q15_ONE) ? tets_pkg::Q15_ONE : cfg.min_scale;
	assign span  = tets_pkg::Q15_ONE - smin;
	assign denom = tets_pkg::DEN_W'(1 << 20) + {1'b0, mul_q};
	assign ge    = {{(tets_pkg::DSH_W - tets_pkg::NUM_W){1'b0}}, rem_q} >= dsh_q;

	assign raw_sum = {1'b0, smin} + {1'b0, quot_q};
	assign raw     = (raw_sum > {1'b0, tets_pkg::Q15_ONE}) ? tets_pkg::Q15_ONE : raw_sum[15:0];

	// step rounds toward the previous scale
	assign s_sum = up_q ? ({1'b0, scale_q} + {1'b0, mul_q[31:16]})
	                    : ({1'b0, scale_q} - {1'b0, mul_q[31:16]});

	always_comb begin
		if (s_sum < {1'b0, smin}) begin
			s_new = smin;
		end else if (s_sum > {1'b0, tets_pkg::Q15_ONE}) begin
			s_new = tets_pkg::Q15_ONE;
		end else begin
			s_new = s_sum[15:0];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			abs_pos_q <= apos[15:0];
			abs_vel_q <= avel[15:0];
			last_q    <= last_joint;
		end
		if (cmd.mul_en) begin
			mul_q <= mul_a * mul_b;
		end
		if (cmd.z_en) begin
			z_q <= z_sum[16] ? tets_pkg::SAT16 : z_sum[15:0];
		end
		if (cmd.div_init) begin
			rem_q  <= {span, 20'b0};
			dsh_q  <= {denom, {(tets_pkg::DIV_STEPS - 1){1'b0}}};
			quot_q <= '0;
		end else if (cmd.div_step) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q[tets_pkg::NUM_W-1:0];
			end
			quot_q <= {quot_q[14:0], ge};
			dsh_q  <= dsh_q >> 1;
		end
		if (cmd.raw_en) begin
			up_q   <= raw >= scale_q;
			diff_q <= (raw >= scale_q) ? (raw - scale_q) : (scale_q - raw);
		end
	end

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pos_q <= '0;
			max_vel_q <= '0;
			scale_q   <= tets_pkg::Q15_ONE;
		end else begin
			if (cmd.fin_en) begin
				max_pos_q <= '0;
				max_vel_q <= '0;
				scale_q   <= s_new;
			end else begin
				if (cmd.upd_pos && (pos_err > max_pos_q)) begin
					max_pos_q <= pos_err;
				end
				if (cmd.upd_vel && (vel_err > max_vel_q)) begin
					max_vel_q <= vel_err;
				end
			end
		end
	end

	assign stat.last   = last_q;
	assign speed_scale = scale_q;

endmodule

@@ sv/tracking_error_time_scale_unit.sv @@
// tracking error time scale unit: takes one joint word per item (reference and
// measured position and velocity, plus a last-joint mark) and keeps the running
// maximum of the tolerance-normalized position and velocity errors, Q8.8 and
// saturated. on the word marked last it forms z = max pos err + lambda * max vel
// err, the raw scale s_min + (1 - s_min)/(1 + k*z), low-pass filters it against
// the previous scale, clamps it to [s_min, 1.0] and returns one speed_scale word
// (Q1.15, 32768 = 1.0); then the maxima clear. other words return nothing.
// one word is worked at a time through a shared 16x16 multiplier: a joint that
// is not last runs the position and velocity products; the last joint also runs
// lambda, k*z, the restoring divider (one quotient bit per cycle) and the filter
// step, and waits while the output is held by stall. a finished word waits in
// the output register while the next joint is taken in. registers are written
// through cfg_we / cfg_index / cfg_data, by the user only while idle; the block does not enforce it.

`include "tracking_error_time_scale_unit_defines.svh"

module tracking_error_time_scale_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [tets_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tets_pkg::DATA_W-1:0]       cfg_data,
	// joint words
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [15:0]                pos_ref,
	input  logic signed [15:0]                pos_meas,
	input  logic signed [15:0]                vel_ref,
	input  logic signed [15:0]                vel_meas,
	input  logic                              last_joint,
	// speed scale words
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tets_pkg::DATA_W-1:0]       speed_scale
);

	tets_pkg::cfg_t  cfg;
	tets_pkg::cmd_t  cmd;
	tets_pkg::stat_t stat;

	// register file
	tets_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer: steps the multiplier, divider and filter, owns the handshakes
	tets_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// arithmetic, maxima and the stored scale (which is also the output word)
	tets_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.stat        (stat),
		.pos_ref     (pos_ref),
		.pos_meas    (pos_meas),
		.vel_ref     (vel_ref),
		.vel_meas    (vel_meas),
		.last_joint  (last_joint),
		.speed_scale (speed_scale)
	);

	// nothing else runs while a joint word is taken
	`TETS_ASSERT_IMP(a_accept_quiet, in_valid && !in_stall, !cmd.fin_en && !cmd.div_step && !cmd.mul_en)
	// a new scale always shows up as a pending word
	`TETS_ASSERT_NXT(a_fin_valid, cmd.fin_en, out_valid)
	// the filtered scale never exceeds one
	`TETS_ASSERT_NXT(a_fin_range, cmd.fin_en, speed_scale <= tets_pkg::Q15_ONE)
	// the divider starts stepping right after it is loaded
	`TETS_ASSERT_NXT(a_div_start, cmd.div_init, cmd.div_step)

endmodule
